// ===== rtl/sact_pkg.sv =====
`timescale 1ns / 1ps
package sact_pkg;

  localparam int FIELD_W           = 60;
  localparam int CFG_W             = 8;
  localparam int COORD_WIDTH_DEF   = 20;
  localparam int TIME_FRAC_DEF     = 16;
  localparam logic [CFG_W-1:0] ZVL_RESET = 8'd1;
  localparam int NUM_AXES          = 3;

  // Normal codes
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;
  localparam logic signed [1:0] NORM_NONE = 2'sb00;

  typedef struct packed {
    logic motionless;
    logic outside;
    logic swapped;
  } lane_flags_t;

endpackage

// ===== rtl/sact_in_if.sv =====
`timescale 1ns / 1ps
interface sact_in_if import sact_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] mover_min;
  logic [FIELD_W-1:0] mover_max;
  logic [FIELD_W-1:0] velocity;
  logic [FIELD_W-1:0] obstacle_min;
  logic [FIELD_W-1:0] obstacle_max;

  modport source (output valid, mover_min, mover_max, velocity, obstacle_min, obstacle_max,
                  input ready);
  modport sink (input valid, mover_min, mover_max, velocity, obstacle_min, obstacle_max,
                output ready);
endinterface

// ===== rtl/sact_out_if.sv =====
`timescale 1ns / 1ps
interface sact_out_if import sact_pkg::*; #(
  parameter int TIME_FRAC_BITS = TIME_FRAC_DEF
) ();
  logic                      valid;
  logic                      ready;
  logic [TIME_FRAC_BITS:0]   hit_time;
  logic signed [1:0]         normal_x;
  logic signed [1:0]         normal_y;
  logic signed [1:0]         normal_z;

  modport source (output valid, hit_time, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, hit_time, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== rtl/sact_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: floor(+-mag * 2^TF / den), saturated to +-2^(TF+1).
// One quotient bit per stage, TF+2 stages after the input register.
module sact_div import sact_pkg::*; #(
  parameter int MAG_W = 23,
  parameter int DEN_W = 21,
  parameter int TF    = TIME_FRAC_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 neg_i,
  input  logic [MAG_W-1:0]     mag_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic signed [TF+2:0] t_o
);
  localparam int S = TF + 2;

  logic [MAG_W-1:0] r_q   [S+1];
  logic [S-1:0]     q_q   [S+1];
  logic [DEN_W-1:0] den_q [S+1];
  logic             neg_q [S+1];
  logic             sat_q [S+1];

  logic [MAG_W+1:0] den_x4;
  assign den_x4 = {(MAG_W+2)'(den_i)} << 2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= mag_i;
      q_q[0]   <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      sat_q[0] <= ((MAG_W+2)'(mag_i) >= den_x4);
    end
  end

  for (genvar j = 0; j < S; j++) begin : g_stage
    logic [MAG_W:0]   rsh;
    logic [MAG_W:0]   dsh;
    logic [MAG_W:0]   rdif;
    logic             ge;
    logic [S-1:0]     qn;

    always_comb begin
      if (j == 0) begin
        rsh = {1'b0, r_q[j]};
        dsh = (MAG_W+1)'(den_q[j]) << 1;
      end else if (j == 1) begin
        rsh = {1'b0, r_q[j]};
        dsh = (MAG_W+1)'(den_q[j]);
      end else begin
        rsh = {r_q[j], 1'b0};
        dsh = (MAG_W+1)'(den_q[j]);
      end
      ge   = (rsh >= dsh);
      rdif = ge ? (rsh - dsh) : rsh;
      qn   = q_q[j];
      qn[S-1-j] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]   <= rdif[MAG_W-1:0];
        q_q[j+1]   <= qn;
        den_q[j+1] <= den_q[j];
        neg_q[j+1] <= neg_q[j];
        sat_q[j+1] <= sat_q[j];
      end
    end
  end

  // Floor correction and saturation
  localparam logic [TF+2:0] LIM = (TF+3)'(1) << (TF+1);
  logic [TF+2:0] qp;
  logic [TF+2:0] qm;
  logic [TF+2:0] mag_sat;

  always_comb begin
    qp = (TF+3)'(q_q[S]);
    qm = qp + (TF+3)'(|r_q[S]);
    if (neg_q[S]) begin
      mag_sat = (sat_q[S] || qm > LIM) ? LIM : qm;
      t_o     = -$signed(mag_sat);
    end else begin
      mag_sat = (sat_q[S] || qp > LIM) ? LIM : qp;
      t_o     = $signed(mag_sat);
    end
  end
endmodule

// ===== rtl/sact_lane.sv =====
`timescale 1ns / 1ps
// One axis: slab setup, two dividers, near/far ordering.
module sact_lane import sact_pkg::*; #(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_DEF
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [CFG_W-1:0]                 limit_i,
  input  logic signed [COORD_WIDTH-1:0]    mmin_i,
  input  logic signed [COORD_WIDTH-1:0]    mmax_i,
  input  logic signed [COORD_WIDTH-1:0]    vel_i,
  input  logic signed [COORD_WIDTH-1:0]    smin_i,
  input  logic signed [COORD_WIDTH-1:0]    smax_i,
  output lane_flags_t                      flags_o,
  output logic signed [TIME_FRAC_BITS+2:0] tn_o,
  output logic signed [TIME_FRAC_BITS+2:0] tf_o
);
  localparam int W  = COORD_WIDTH;
  localparam int NW = W + 3;
  localparam int S  = TIME_FRAC_BITS + 2;

  logic signed [NW-1:0] o2, ext, lo2, hi2, n1, n2;
  logic [W-1:0]         av;
  logic [W:0]           den;
  logic                 motionless, outside, neg1, neg2;
  logic [NW-1:0]        mag1, mag2;

  always_comb begin
    o2   = NW'(mmin_i) + NW'(mmax_i);
    ext  = NW'(mmax_i) - NW'(mmin_i);
    lo2  = (NW'(smin_i) <<< 1) - ext;
    hi2  = (NW'(smax_i) <<< 1) + ext;
    n1   = lo2 - o2;
    n2   = hi2 - o2;
    av   = vel_i[W-1] ? W'(-vel_i) : W'(vel_i);
    den  = {av, 1'b0};
    motionless = (av == '0) || (av < W'(limit_i));
    outside    = (o2 < lo2) || (o2 > hi2);
    neg1 = n1[NW-1] ^ vel_i[W-1];
    neg2 = n2[NW-1] ^ vel_i[W-1];
    mag1 = n1[NW-1] ? NW'(-n1) : NW'(n1);
    mag2 = n2[NW-1] ? NW'(-n2) : NW'(n2);
  end

  logic signed [TIME_FRAC_BITS+2:0] t1, t2;

  sact_div #(.MAG_W(NW), .DEN_W(W+1), .TF(TIME_FRAC_BITS)) u_div_lo (
    .clk_i, .en_i, .neg_i(neg1), .mag_i(mag1), .den_i(den), .t_o(t1)
  );
  sact_div #(.MAG_W(NW), .DEN_W(W+1), .TF(TIME_FRAC_BITS)) u_div_hi (
    .clk_i, .en_i, .neg_i(neg2), .mag_i(mag2), .den_i(den), .t_o(t2)
  );

  // Side info travels alongside the divider pipeline
  logic mot_q [S+1];
  logic out_q [S+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mot_q[0] <= motionless;
      out_q[0] <= outside;
      for (int k = 0; k < S; k++) begin
        mot_q[k+1] <= mot_q[k];
        out_q[k+1] <= out_q[k];
      end
    end
  end

  logic swap;
  assign swap = (t1 > t2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_o.motionless <= mot_q[S];
      flags_o.outside    <= out_q[S];
      flags_o.swapped    <= swap;
      tn_o <= swap ? t2 : t1;
      tf_o <= swap ? t1 : t2;
    end
  end
endmodule

// ===== rtl/sact_merge.sv =====
`timescale 1ns / 1ps
// Combines the three slabs in axis order into entry time and normal.
module sact_merge import sact_pkg::*; #(
  parameter int TIME_FRAC_BITS = TIME_FRAC_DEF
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  lane_flags_t                      flags_i [NUM_AXES],
  input  logic signed [TIME_FRAC_BITS+2:0] tn_i    [NUM_AXES],
  input  logic signed [TIME_FRAC_BITS+2:0] tf_i    [NUM_AXES],
  output logic [TIME_FRAC_BITS:0]          hit_time_o,
  output logic signed [1:0]                normal_x_o,
  output logic signed [1:0]                normal_y_o,
  output logic signed [1:0]                normal_z_o
);
  localparam int TF = TIME_FRAC_BITS;
  localparam logic signed [TF+2:0] ONE = (TF+3)'(1) << TF;

  logic signed [TF+2:0] enter, exit_t;
  logic                 miss;
  logic signed [1:0]    nrm [NUM_AXES];

  always_comb begin
    enter  = '0;
    exit_t = ONE;
    miss   = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) nrm[a] = NORM_NONE;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!miss) begin
        if (flags_i[a].motionless) begin
          miss = flags_i[a].outside;
        end else begin
          if (tn_i[a] > enter) begin
            enter = tn_i[a];
            for (int k = 0; k < NUM_AXES; k++) nrm[k] = NORM_NONE;
            nrm[a] = flags_i[a].swapped ? NORM_POS : NORM_NEG;
          end
          if (tf_i[a] < exit_t) exit_t = tf_i[a];
          if (enter > exit_t || exit_t < 0) miss = 1'b1;
        end
      end
    end
    if (enter < 0 || enter > ONE) miss = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_time_o <= miss ? ONE[TF:0] : enter[TF:0];
      normal_x_o <= miss ? NORM_NONE : nrm[0];
      normal_y_o <= miss ? NORM_NONE : nrm[1];
      normal_z_o <= miss ? NORM_NONE : nrm[2];
    end
  end
endmodule

// ===== rtl/swept_aabb_collision_time.sv =====
`timescale 1ns / 1ps
// Swept box collision time, slab test on three parallel axis lanes.
// Pipeline: input register, the bit-per-stage dividers (TIME_FRAC_BITS + 2 stages) in each lane,
//   the lane register and the merge stage, which doubles as the output register.
// Throughput: one transaction per cycle; a stalled output holds the whole pipeline.
// Reset (rst_ni, async, active low) clears all valid bits and sets
//   zero_velocity_limit to 1; datapath registers are not reset.
module swept_aabb_collision_time import sact_pkg::*; #(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  sact_in_if.sink          in_i,
  sact_out_if.source       out_o
);
  localparam int W = COORD_WIDTH;
  // input reg + divider stages + lane reg
  localparam int D = TIME_FRAC_BITS + 4;

  // Config register: to be written only while idle; the block does not enforce it, the user must.
  logic [CFG_W-1:0] zvl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zvl_q <= ZVL_RESET;
    end else if (cfg_we_i) begin
      zvl_q <= cfg_wdata_i;
    end
  end

  // Whole pipeline advances together; a bubble or a taken result frees it.
  logic adv;
  logic out_vld_q;
  logic [D-1:0] vld_q;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[D-2:0], in_i.valid};
      out_vld_q <= vld_q[D-1];
    end
  end

  assign out_o.valid = out_vld_q;

  // Per-axis lanes
  lane_flags_t                      flags [NUM_AXES];
  logic signed [TIME_FRAC_BITS+2:0] tn    [NUM_AXES];
  logic signed [TIME_FRAC_BITS+2:0] tf    [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    sact_lane #(.COORD_WIDTH(W), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_lane (
      .clk_i,
      .en_i   (adv),
      .limit_i(zvl_q),
      .mmin_i (in_i.mover_min[a*W +: W]),
      .mmax_i (in_i.mover_max[a*W +: W]),
      .vel_i  (in_i.velocity[a*W +: W]),
      .smin_i (in_i.obstacle_min[a*W +: W]),
      .smax_i (in_i.obstacle_max[a*W +: W]),
      .flags_o(flags[a]),
      .tn_o   (tn[a]),
      .tf_o   (tf[a])
    );
  end

  // Merge stage doubles as the output register
  sact_merge #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_merge (
    .clk_i,
    .en_i      (adv),
    .flags_i   (flags),
    .tn_i      (tn),
    .tf_i      (tf),
    .hit_time_o(out_o.hit_time),
    .normal_x_o(out_o.normal_x),
    .normal_y_o(out_o.normal_y),
    .normal_z_o(out_o.normal_z)
  );
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sact_pkg::*;

  localparam int CW      = COORD_WIDTH_DEF;
  localparam int TF      = TIME_FRAC_DEF;
  localparam int LAT     = TF + 5;
  localparam int WD_MAX  = 4000;
  localparam longint T1  = longint'(1) << TF;

  typedef struct packed {
    logic [FIELD_W-1:0] mmin;
    logic [FIELD_W-1:0] mmax;
    logic [FIELD_W-1:0] vel;
    logic [FIELD_W-1:0] omin;
    logic [FIELD_W-1:0] omax;
  } query_t;

  typedef struct packed {
    logic [TF:0]       t;
    logic signed [1:0] nx;
    logic signed [1:0] ny;
    logic signed [1:0] nz;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  sact_in_if  in_if ();
  sact_out_if out_if ();

  swept_aabb_collision_time i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predictor copy of the motionless-axis threshold.
  logic [CFG_W-1:0] zvl_model = ZVL_RESET;

  query_t   query_q[$];
  contact_t contact_q[$];
  int       errors = 0;
  int       wd_cnt = 0;
  bit       burst_on = 1'b0;
  int       burst_left = 0;
  int       rx_phase = 0;
  // Input transaction taken at the last rising edge.
  bit       in_taken = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint coord_of(logic [FIELD_W-1:0] w, int a);
    logic signed [CW-1:0] c;
    c = w[a*CW +: CW];
    return longint'(c);
  endfunction

  // floor(num * 2^TF / den), clamped to +/-2.0
  function automatic longint slab_quot(longint num, longint den);
    longint p, q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    p = num * T1;
    q = p / den;
    if (p % den != 0 && p < 0) q--;
    if (q > 2 * T1) q = 2 * T1;
    if (q < -2 * T1) q = -2 * T1;
    return q;
  endfunction

  function automatic contact_t sweep_contact(query_t qy);
    contact_t r, miss;
    longint t_in, t_out, o2, ext, lo2, hi2, v, av, ta, tb;
    int n_ax;
    logic signed [1:0] n_sg, sg;
    t_in = 0;
    t_out = T1;
    n_ax = -1;
    n_sg = NORM_NONE;
    miss = '{t: T1[TF:0], nx: NORM_NONE, ny: NORM_NONE, nz: NORM_NONE};
    for (int a = 0; a < NUM_AXES; a++) begin
      o2  = coord_of(qy.mmin, a) + coord_of(qy.mmax, a);
      ext = coord_of(qy.mmax, a) - coord_of(qy.mmin, a);
      lo2 = 2 * coord_of(qy.omin, a) - ext;
      hi2 = 2 * coord_of(qy.omax, a) + ext;
      v   = coord_of(qy.vel, a);
      av  = v < 0 ? -v : v;
      if (v == 0 || av < longint'(zvl_model)) begin
        if (o2 < lo2 || o2 > hi2) return miss;
      end else begin
        ta = slab_quot(lo2 - o2, 2 * v);
        tb = slab_quot(hi2 - o2, 2 * v);
        sg = NORM_NEG;
        if (ta > tb) begin
          {ta, tb} = {tb, ta};
          sg = NORM_POS;
        end
        if (ta > t_in) begin
          t_in = ta;
          n_ax = a;
          n_sg = sg;
        end
        if (tb < t_out) t_out = tb;
        if (t_in > t_out || t_out < 0) return miss;
      end
    end
    if (t_in < 0 || t_in > T1) return miss;
    r.t  = t_in[TF:0];
    r.nx = n_ax == 0 ? n_sg : NORM_NONE;
    r.ny = n_ax == 1 ? n_sg : NORM_NONE;
    r.nz = n_ax == 2 ? n_sg : NORM_NONE;
    return r;
  endfunction

  function automatic logic [CW-1:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($urandom);
      default: return CW'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pack3(logic [CW-1:0] x, y, z);
    return {z, y, x};
  endfunction

  // Mostly well-formed boxes that sit near each other so hits are common.
  function automatic query_t rnd_query();
    query_t qy;
    logic [CW-1:0] c[5][3];
    int base, sz;
    if ($urandom_range(0, 9) == 0) begin
      for (int f = 0; f < 5; f++)
        for (int a = 0; a < 3; a++) c[f][a] = rnd_coord();
    end else begin
      for (int a = 0; a < 3; a++) begin
        base = $urandom_range(0, 4000) - 2000;
        sz = $urandom_range(0, 600);
        c[0][a] = CW'(base);
        c[1][a] = CW'(base + sz);
        base = base + $urandom_range(0, 3000) - 1500;
        sz = $urandom_range(0, 800);
        c[3][a] = CW'(base);
        c[4][a] = CW'(base + sz);
        case ($urandom_range(0, 5))
          0: c[2][a] = '0;
          1: c[2][a] = CW'($urandom_range(0, 8) - 4);
          2: c[2][a] = rnd_coord();
          default: c[2][a] = CW'($urandom_range(0, 6000) - 3000);
        endcase
      end
    end
    qy.mmin = pack3(c[0][0], c[0][1], c[0][2]);
    qy.mmax = pack3(c[1][0], c[1][1], c[1][2]);
    qy.vel  = pack3(c[2][0], c[2][1], c[2][2]);
    qy.omin = pack3(c[3][0], c[3][1], c[3][2]);
    qy.omax = pack3(c[4][0], c[4][1], c[4][2]);
    return qy;
  endfunction

  function automatic query_t mk_query(int mlo, int mhi, int v, int olo, int ohi);
    query_t qy;
    qy.mmin = pack3(CW'(mlo), '0, '0);
    qy.mmax = pack3(CW'(mhi), '0, '0);
    qy.vel  = pack3(CW'(v), '0, '0);
    qy.omin = pack3(CW'(olo), '0, '0);
    qy.omax = pack3(CW'(ohi), '0, '0);
    return qy;
  endfunction

  // Write the threshold only with the pipe drained; extra cycles cover latency.
  task automatic set_zvl(logic [CFG_W-1:0] val);
    while (query_q.size() != 0 || contact_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    zvl_model = val;
  endtask

  // Driver: bursts of transactions with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (burst_left == 0) begin
          burst_on = !burst_on;
          burst_left = burst_on ? $urandom_range(1, 40) : $urandom_range(0, 6);
        end
        if (burst_left > 0) burst_left--;
        if (burst_on && query_q.size() != 0) begin
          in_if.valid        <= 1'b1;
          in_if.mover_min    <= query_q[0].mmin;
          in_if.mover_max    <= query_q[0].mmax;
          in_if.velocity     <= query_q[0].vel;
          in_if.obstacle_min <= query_q[0].omin;
          in_if.obstacle_max <= query_q[0].omax;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      // Receiver stalls: periodic pattern with a random component, calm stretches.
      rx_phase = (rx_phase + 1) % 512;
      out_if.ready <= rx_phase < 128 ? 1'b1 :
                      ((rx_phase % 7) < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: predict on input transactions, check on output transactions.
  always @(posedge clk_i) begin
    contact_t got, exp_c;
    if (rst_ni) begin
      in_taken = in_if.valid && in_if.ready;
      if (in_taken)
        contact_q.push_back(sweep_contact(query_q.pop_front()));
      if (out_if.valid && out_if.ready) begin
        got = '{t: out_if.hit_time, nx: out_if.normal_x, ny: out_if.normal_y,
                nz: out_if.normal_z};
        if (contact_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result t=%0d", got.t);
        end else begin
          exp_c = contact_q.pop_front();
          if (got !== exp_c) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp t=%0d n=%0d,%0d,%0d got t=%0d n=%0d,%0d,%0d",
                       exp_c.t, exp_c.nx, exp_c.ny, exp_c.nz,
                       got.t, got.nx, got.ny, got.nz);
          end
        end
      end
      // Watchdog on cycles without any transaction.
      if (in_taken || (out_if.valid && out_if.ready)) wd_cnt = 0;
      else wd_cnt++;
      if (wd_cnt >= WD_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.mover_min = '0;
    in_if.mover_max = '0;
    in_if.velocity = '0;
    in_if.obstacle_min = '0;
    in_if.obstacle_max = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: head-on hits from both sides, miss, grazing, inside at t=0,
    // zero velocity, extremes and inverted boxes.
    query_q.push_back(mk_query(0, 256, 1024, 512, 768));
    query_q.push_back(mk_query(1000, 1256, -1024, 0, 256));
    query_q.push_back(mk_query(0, 256, 100, 5000, 5256));
    query_q.push_back(mk_query(0, 256, 256, 512, 768));
    query_q.push_back(mk_query(0, 256, 0, 100, 200));
    query_q.push_back(mk_query(0, 256, 0, 1000, 2000));
    query_q.push_back(mk_query(600, 700, 50, 0, 256));
    query_q.push_back(mk_query(256, 0, 512, 768, 512));
    query_q.push_back(mk_query(-524288, 524287, 524287, -524288, 524287));
    query_q.push_back(mk_query(-524288, -524288, 524287, 524287, 524287));
    query_q.push_back(mk_query(524287, 524287, -524288, -524288, -524288));
    query_q.push_back(mk_query(0, 10, 1, 5, 6));
    query_q.push_back(mk_query(0, 10, -1, 5, 6));
    query_q.push_back('{mmin: '1, mmax: '1, vel: '1, omin: '1, omax: '1});
    query_q.push_back('0);
    for (int i = 0; i < 8; i++) query_q.push_back(rnd_query());

    // Threshold sweep, extremes included; zero makes every nonzero velocity count.
    set_zvl(8'd0);
    for (int i = 0; i < 300; i++) query_q.push_back(rnd_query());
    set_zvl(8'd255);
    query_q.push_back(mk_query(0, 256, 254, 512, 768));
    query_q.push_back(mk_query(0, 256, 255, 512, 768));
    for (int i = 0; i < 300; i++) query_q.push_back(rnd_query());
    set_zvl(8'($urandom_range(2, 254)));
    for (int i = 0; i < 400; i++) query_q.push_back(rnd_query());
    set_zvl(ZVL_RESET);
    for (int i = 0; i < 400; i++) query_q.push_back(rnd_query());

    while (query_q.size() != 0 || contact_q.size() != 0) @(posedge clk_i);
    repeat (LAT * 4) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== swept_aabb_collision_time.f =====
rtl/sact_pkg.sv
rtl/sact_in_if.sv
rtl/sact_out_if.sv
rtl/sact_div.sv
rtl/sact_lane.sv
rtl/sact_merge.sv
rtl/swept_aabb_collision_time.sv
tb/tb_top.sv
